// ===== rtl/fbpa_pkg.sv =====
// Shared types, codes and defaults for the fixed block pool allocator.
// No dependencies; every rtl file imports this package.
package fbpa_pkg;

    // Default sizing of the pool
    localparam int unsigned MAX_BLOCKS_DEF   = 1024;
    localparam int unsigned ALIGN_BYTES_DEF  = 16;
    localparam int unsigned HEADER_BYTES_DEF = 32;

    // Field widths fixed by the interface
    localparam int unsigned INDEX_W   = 10;
    localparam int unsigned REQ_W     = 17;
    localparam int unsigned BPN_W     = 11;
    localparam int unsigned OFFSET_W  = 32;
    localparam int unsigned INUSE_W   = 11;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = REQ_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BPN       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW     = 2'd2;

    // Reset values of the configuration registers
    localparam logic [REQ_W-1:0] REQ_RESET   = 17'd64;
    localparam logic [BPN_W-1:0] BPN_RESET   = 11'd64;
    localparam logic             ALLOW_RESET = 1'b1;

    // Request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] STAT_ALLOCATED = 2'd0;
    localparam logic [1:0] STAT_FREED     = 2'd1;
    localparam logic [1:0] STAT_EXHAUSTED = 2'd2;
    localparam logic [1:0] STAT_INVALID   = 2'd3;

    typedef struct packed {
        logic               mode;
        logic [INDEX_W-1:0] block_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          status;
        logic [INDEX_W-1:0]  granted_index;
        logic [OFFSET_W-1:0] byte_offset;
        logic                new_node;
        logic [INUSE_W-1:0]  blocks_in_use;
    } t_out_item;

    // Blocks opened by one node: zero counts as one, capped at the pool size
    function automatic logic [31:0] f_node_size(input logic [BPN_W-1:0] bpn,
                                                input logic [31:0] max_blocks);
        logic [31:0] n;
        n = (bpn == '0) ? 32'd1 : 32'(bpn);
        return (n > max_blocks) ? max_blocks : n;
    endfunction

endpackage

// ===== rtl/fixed_block_pool_allocator_core.sv =====
// Top level of the fixed block pool allocator: request control and result register.
// Depends on fbpa_pkg, fbpa_stride and fbpa_link_mem.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one request:
//   allocate, or free of a block index. Output channel (o_out_valid /
//   i_out_stall / o_out_data) returns exactly one result per request, in order.
//   Configuration is a valid/ready write port (index 0 requested size,
//   1 blocks per node, 2 allow new node); o_cfg_ready is always high.
//   Request flow: an accepted request reads the link memory entry (recycle
//   head or the block being freed); in the execute state it writes the entry
//   of the granted or freed block and loads the result register. The next request is taken only once it completes.
//   The request after a requested-size write waits while the stride
//   pipeline settles.
//   Reset: a clearing sweep of every entry zeroes the allocated flags;
//   o_in_stall stays high during it. Configuration writes are taken meanwhile.
//   Stall: the result register holds while i_out_stall is high; one further
//   request is taken and waits, uncommitted, until the register frees.
module fixed_block_pool_allocator_core #(
    parameter int unsigned MAX_BLOCKS   = fbpa_pkg::MAX_BLOCKS_DEF,
    parameter int unsigned ALIGN_BYTES  = fbpa_pkg::ALIGN_BYTES_DEF,
    parameter int unsigned HEADER_BYTES = fbpa_pkg::HEADER_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  fbpa_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output fbpa_pkg::t_out_item            o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fbpa_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import fbpa_pkg::*;

    localparam int unsigned IW = $clog2(MAX_BLOCKS);
    localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned XW = $clog2((2 ** REQ_W) + ALIGN_BYTES);
    localparam int unsigned SW = XW + 1;
    localparam int unsigned OW = IW + SW + 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    // Configuration
    logic [BPN_W-1:0] r_bpn;
    logic             r_allow;

    // Allocator state
    logic          r_state;
    logic [IW-1:0] r_head;
    logic          r_rv;
    logic [CW-1:0] r_fresh;
    logic [CW-1:0] r_opened;
    logic [CW-1:0] r_in_use;

    // Request held during execution
    logic          r_mode;
    logic [IW-1:0] r_bi_addr;
    logic          r_bi_ok;

    // Result register
    logic      r_out_valid;
    t_out_item r_out_data;

    logic      n_state;
    logic [IW-1:0] n_head;
    logic      n_rv;
    logic [CW-1:0] n_fresh;
    logic [CW-1:0] n_opened;
    logic [CW-1:0] n_in_use;

    logic          w_in_acc;
    logic          w_cfg_acc;
    logic          w_done;
    logic          w_clearing;
    logic          w_stride_busy;
    logic [SW-1:0] w_stride;
    logic          w_rd_flag;
    logic [IW-1:0] w_rd_link;
    logic [IW-1:0] w_rd_addr;
    logic          w_we;
    logic [IW-1:0] w_wa;
    logic          w_wflag;
    logic [IW-1:0] w_wlink;
    logic [CW-1:0] w_ns;
    logic [CW:0]   w_cap_sum;
    logic [CW-1:0] w_cap_sat;
    logic [IW-1:0] w_idx;
    logic          w_ok;
    logic          w_nn;
    logic [1:0]    w_status;
    logic [OW-1:0] w_off_full;
    t_out_item     w_result;

    assign w_cfg_acc  = i_cfg_valid & o_cfg_ready;
    assign o_cfg_ready = 1'b1;
    assign o_in_stall = (r_state != ST_IDLE) | w_clearing | w_stride_busy;
    assign w_in_acc   = i_in_valid & ~o_in_stall;
    assign w_done     = (r_state == ST_EXEC) & (~r_out_valid | ~i_out_stall);

    // Read the recycle head on allocate, the freed block on free
    assign w_rd_addr = (i_in_data.mode == MODE_ALLOC) ? r_head : IW'(i_in_data.block_index);

    assign w_ns      = CW'(f_node_size(r_bpn, 32'(MAX_BLOCKS)));
    assign w_cap_sum = {1'b0, r_opened} + {1'b0, w_ns};
    assign w_cap_sat = (w_cap_sum > (CW + 1)'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS)
                                                           : w_cap_sum[CW-1:0];

    fbpa_stride #(
        .ALIGN_BYTES (ALIGN_BYTES),
        .HEADER_BYTES(HEADER_BYTES),
        .SW          (SW)
    ) u_stride (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (w_cfg_acc && (i_cfg_index == CFG_REQ_BYTES)),
        .i_wr_data(i_cfg_data),
        .o_stride (w_stride),
        .o_busy   (w_stride_busy)
    );

    fbpa_link_mem #(
        .MAX_BLOCKS(MAX_BLOCKS),
        .IW        (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_in_acc),
        .i_rd_addr (w_rd_addr),
        .o_rd_flag (w_rd_flag),
        .o_rd_link (w_rd_link),
        .i_wr_en   (w_we),
        .i_wr_addr (w_wa),
        .i_wr_flag (w_wflag),
        .i_wr_link (w_wlink),
        .o_clearing(w_clearing)
    );

    // Execute the held request against the link memory read data
    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_rv     = r_rv;
        n_fresh  = r_fresh;
        n_opened = r_opened;
        n_in_use = r_in_use;
        w_we     = 1'b0;
        w_wa     = r_bi_addr;
        w_wflag  = 1'b0;
        w_wlink  = r_head;
        w_idx    = '0;
        w_ok     = 1'b0;
        w_nn     = 1'b0;
        w_status = STAT_INVALID;

        if (r_mode == MODE_ALLOC) begin
            w_ok = 1'b1;
            if (r_rv) begin
                w_idx   = r_head;
                n_head  = w_rd_link;
                w_wlink = w_rd_link;
            end else begin
                w_wlink = '0;
                if (r_fresh >= r_opened) begin
                    if (r_allow && (r_opened < CW'(MAX_BLOCKS))) begin
                        n_opened = w_cap_sat;
                        w_nn     = 1'b1;
                    end else begin
                        w_ok = 1'b0;
                    end
                end
                if (w_ok) begin
                    w_idx   = IW'(r_fresh);
                    n_fresh = r_fresh + CW'(1);
                end
            end
            if (w_ok) begin
                w_we     = 1'b1;
                w_wa     = w_idx;
                w_wflag  = 1'b1;
                n_in_use = r_in_use + CW'(1);
                n_rv     = (n_fresh != n_in_use);
                w_status = STAT_ALLOCATED;
            end else begin
                w_status = STAT_EXHAUSTED;
            end
        end else begin
            if (r_bi_ok && w_rd_flag) begin
                w_we     = 1'b1;
                w_wa     = r_bi_addr;
                w_wflag  = 1'b0;
                w_wlink  = r_head;
                n_head   = r_bi_addr;
                n_in_use = (r_in_use != '0) ? (r_in_use - CW'(1)) : r_in_use;
                n_rv     = 1'b1;
                w_status = STAT_FREED;
            end
        end

        // Commit only when the result register can take the result
        if (!w_done) begin
            n_head   = r_head;
            n_rv     = r_rv;
            n_fresh  = r_fresh;
            n_opened = r_opened;
            n_in_use = r_in_use;
            w_we     = 1'b0;
        end

        if (w_in_acc) begin
            n_state = ST_EXEC;
        end else if (w_done) begin
            n_state = ST_IDLE;
        end
    end

    assign w_off_full = OW'(w_idx) * OW'(w_stride) + OW'(HEADER_BYTES);

    always_comb begin
        w_result.status        = w_status;
        w_result.granted_index = w_ok ? INDEX_W'(w_idx) : '0;
        w_result.byte_offset   = w_ok ? OFFSET_W'(w_off_full) : '0;
        w_result.new_node      = w_ok & w_nn;
        w_result.blocks_in_use = INUSE_W'(n_in_use);
    end

    // Hold allocator state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_head   <= '0;
            r_rv     <= 1'b0;
            r_fresh  <= '0;
            r_in_use <= '0;
            r_opened <= CW'(f_node_size(BPN_RESET, 32'(MAX_BLOCKS)));
            r_bpn    <= BPN_RESET;
            r_allow  <= ALLOW_RESET;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_rv     <= n_rv;
            r_fresh  <= n_fresh;
            r_in_use <= n_in_use;
            // A node size written before the first allocation resizes the open node
            if (w_cfg_acc && (i_cfg_index == CFG_BPN) && (r_fresh == '0)) begin
                r_opened <= CW'(f_node_size(i_cfg_data[BPN_W-1:0], 32'(MAX_BLOCKS)));
            end else begin
                r_opened <= n_opened;
            end
            if (w_cfg_acc && (i_cfg_index == CFG_BPN)) begin
                r_bpn <= i_cfg_data[BPN_W-1:0];
            end
            if (w_cfg_acc && (i_cfg_index == CFG_ALLOW)) begin
                r_allow <= i_cfg_data[0];
            end
        end
    end

    // Capture the request on transfer
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mode    <= i_in_data.mode;
            r_bi_addr <= IW'(i_in_data.block_index);
            r_bi_ok   <= (32'(i_in_data.block_index) < 32'(MAX_BLOCKS));
        end
    end

    // Result register: load on completion, drop after the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_data <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // The recycle list is non-empty exactly when freed blocks are waiting
    a_rv_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rv == (r_fresh != r_in_use))
        else $error("recycle flag disagrees with fresh and in-use counts");

    a_use_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_use <= r_fresh) && (r_fresh <= r_opened) && (r_opened <= CW'(MAX_BLOCKS)))
        else $error("block counters out of order");

    a_no_exec_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((r_state == ST_EXEC) && w_clearing))
        else $error("request executing during clearing sweep");

endmodule

// ===== rtl/fbpa_stride.sv =====
// Holds the requested block size and derives the block stride from it.
// Three-stage reciprocal pipeline for the alignment round-up; uses fbpa_pkg.
module fbpa_stride #(
    parameter int unsigned ALIGN_BYTES  = fbpa_pkg::ALIGN_BYTES_DEF,
    parameter int unsigned HEADER_BYTES = fbpa_pkg::HEADER_BYTES_DEF,
    parameter int unsigned SW           = 19
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr_en,
    input  logic [fbpa_pkg::REQ_W-1:0] i_wr_data,
    output logic [SW-1:0]             o_stride,
    output logic                      o_busy
);
    import fbpa_pkg::*;

    // x = req + ALIGN - 1 always stays below 2^XW
    localparam int unsigned XW    = $clog2((2 ** REQ_W) + ALIGN_BYTES);
    localparam int unsigned S     = XW;
    localparam int unsigned PW    = XW + S + 1;
    localparam logic [S:0]  RECIP = (S + 1)'((2 ** S) / ALIGN_BYTES);

    logic [REQ_W-1:0] r_req;
    logic [PW-1:0]    r_prod;
    logic [XW-1:0]    r_qa;
    logic [SW-1:0]    r_stride;
    logic [1:0]       r_busy_cnt;

    logic [XW-1:0]    w_x;
    logic [XW:0]      w_q_est;
    logic [XW-1:0]    w_rem;
    logic [XW-1:0]    w_qa_fix;

    assign w_x     = XW'(r_req) + XW'(ALIGN_BYTES - 1);
    assign w_q_est = r_prod[PW-1:S];
    assign w_rem   = w_x - r_qa;
    // The estimate is low by at most one quotient step
    assign w_qa_fix = (w_rem >= XW'(ALIGN_BYTES)) ? (r_qa + XW'(ALIGN_BYTES)) : r_qa;

    // Hold the size register and count down the settle time after a write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req      <= REQ_RESET;
            r_busy_cnt <= 2'd3;
        end else if (i_wr_en) begin
            r_req      <= i_wr_data;
            r_busy_cnt <= 2'd3;
        end else if (r_busy_cnt != 2'd0) begin
            r_busy_cnt <= r_busy_cnt - 2'd1;
        end
    end

    // Advance the round-up pipeline
    always_ff @(posedge i_clk) begin
        r_prod   <= PW'(w_x) * PW'(RECIP);
        r_qa     <= XW'(w_q_est * (XW + 1)'(ALIGN_BYTES));
        r_stride <= SW'(w_qa_fix) + SW'(HEADER_BYTES);
    end

    assign o_stride = r_stride;
    assign o_busy   = (r_busy_cnt != 2'd0);

endmodule

// ===== rtl/fbpa_link_mem.sv =====
// Link memory: allocated flag and next-pointer per block, one read and one write port.
// Sweeps every entry clear after reset; takes its default pool size from fbpa_pkg.
module fbpa_link_mem #(
    parameter int unsigned MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF,
    parameter int unsigned IW         = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [IW-1:0] i_rd_addr,
    output logic          o_rd_flag,
    output logic [IW-1:0] o_rd_link,
    input  logic          i_wr_en,
    input  logic [IW-1:0] i_wr_addr,
    input  logic          i_wr_flag,
    input  logic [IW-1:0] i_wr_link,
    output logic          o_clearing
);
    import fbpa_pkg::*;

    logic [IW:0]   r_mem [MAX_BLOCKS];
    logic [IW:0]   r_rd_data;
    logic          r_clearing;
    logic [IW-1:0] r_clr_addr;

    logic          w_we;
    logic [IW-1:0] w_wa;
    logic [IW:0]   w_wd;

    // Sweep owns the write port until every entry is clear
    assign w_we = r_clearing | i_wr_en;
    assign w_wa = r_clearing ? r_clr_addr : i_wr_addr;
    assign w_wd = r_clearing ? '0 : {i_wr_flag, i_wr_link};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + IW'(1);
            if (r_clr_addr == IW'(MAX_BLOCKS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_flag  = r_rd_data[IW];
    assign o_rd_link  = r_rd_data[IW-1:0];
    assign o_clearing = r_clearing;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for fixed_block_pool_allocator_core: directed and random
// allocate/free traffic checked against an in-bench pool model. Depends on fbpa_pkg and the core.
module tb_top;
    import fbpa_pkg::*;

    localparam int unsigned POOL_BLOCKS    = MAX_BLOCKS_DEF;
    localparam int unsigned QUIET_LIMIT    = 4000;
    localparam int unsigned RX_HOLD_CYCLES = 300;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    t_in_item             in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_item            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    // Pool model: configuration copy and allocator state
    logic [REQ_W-1:0]   m_req_bytes;
    logic [BPN_W-1:0]   m_bpn;
    logic               m_allow;
    logic [INDEX_W-1:0] m_link [POOL_BLOCKS];
    bit                 m_taken [POOL_BLOCKS];
    logic [INDEX_W-1:0] m_head;
    bit                 m_head_valid;
    int unsigned        m_fresh;
    int unsigned        m_capacity;
    int unsigned        m_in_use;

    // Blocks currently held, used to aim frees at live blocks
    int unsigned live_blocks[$];
    t_out_item   pending_results[$];
    t_out_item   want;

    int unsigned tx_idle_max   = 0;
    int unsigned rx_idle_max   = 0;
    int unsigned hold_requests = 0;
    int unsigned holds_served  = 0;
    int unsigned rx_hold_left  = 0;
    int unsigned rx_wait       = 0;
    int unsigned results_seen  = 0;

    int unsigned n_requests       = 0;
    int unsigned n_results        = 0;
    int unsigned n_errors         = 0;
    int unsigned n_new_nodes      = 0;
    int unsigned n_exhausted      = 0;
    int unsigned n_full_exhausted = 0;
    int unsigned n_invalid        = 0;

    fixed_block_pool_allocator_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Blocks opened by one node: zero means one, never more than the pool
    function automatic int unsigned node_blocks();
        int unsigned n;
        n = (m_bpn == '0) ? 1 : m_bpn;
        return (n > POOL_BLOCKS) ? POOL_BLOCKS : n;
    endfunction

    // Payload offset of a block: header plus index times the aligned stride
    function automatic logic [OFFSET_W-1:0] payload_offset(input int unsigned idx);
        longint unsigned req;
        longint unsigned stride;
        req    = m_req_bytes;
        stride = ((req + ALIGN_BYTES_DEF - 1) / ALIGN_BYTES_DEF) * ALIGN_BYTES_DEF
                 + HEADER_BYTES_DEF;
        return OFFSET_W'(idx * stride + HEADER_BYTES_DEF);
    endfunction

    function automatic void pool_reset();
        m_req_bytes  = REQ_RESET;
        m_bpn        = BPN_RESET;
        m_allow      = ALLOW_RESET;
        m_head       = '0;
        m_head_valid = 1'b0;
        m_fresh      = 0;
        m_in_use     = 0;
        for (int k = 0; k < POOL_BLOCKS; k++) begin
            m_link[k]  = '0;
            m_taken[k] = 1'b0;
        end
        m_capacity = node_blocks();
    endfunction

    function automatic void pool_config(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DAT_W-1:0] value);
        case (idx)
            CFG_REQ_BYTES: m_req_bytes = value[REQ_W-1:0];
            CFG_BPN: begin
                m_bpn = value[BPN_W-1:0];
                // A node size set before the first allocation resizes the open node
                if (m_fresh == 0) m_capacity = node_blocks();
            end
            CFG_ALLOW: m_allow = value[0];
            default: ;
        endcase
    endfunction

    // Apply one request to the pool model and return its result
    function automatic t_out_item pool_step(input t_in_item req);
        t_out_item   res;
        int unsigned idx;
        int unsigned grown;
        bit          ok;
        bit          found;
        res = '0;
        if (req.mode == MODE_ALLOC) begin
            ok  = 1'b1;
            idx = 0;
            if (m_head_valid) begin
                // Pop the most recently freed block
                idx    = m_head;
                m_head = m_link[idx];
            end else begin
                if (m_fresh >= m_capacity) begin
                    if (m_allow && m_capacity < POOL_BLOCKS) begin
                        grown        = m_capacity + node_blocks();
                        m_capacity   = (grown > POOL_BLOCKS) ? POOL_BLOCKS : grown;
                        res.new_node = 1'b1;
                        n_new_nodes++;
                    end else begin
                        ok = 1'b0;
                    end
                end
                if (ok) begin
                    idx = m_fresh;
                    m_fresh++;
                end
            end
            if (ok) begin
                m_taken[idx] = 1'b1;
                m_in_use++;
                m_head_valid      = (m_fresh != m_in_use);
                res.status        = STAT_ALLOCATED;
                res.granted_index = INDEX_W'(idx);
                res.byte_offset   = payload_offset(idx);
                live_blocks.push_back(idx);
            end else begin
                res.status = STAT_EXHAUSTED;
                n_exhausted++;
                if (m_capacity == POOL_BLOCKS) n_full_exhausted++;
            end
        end else begin
            // Every 10-bit index lies inside the pool, so only the flag decides
            if (m_taken[req.block_index]) begin
                m_taken[req.block_index] = 1'b0;
                m_link[req.block_index]  = m_head;
                m_head                   = req.block_index;
                if (m_in_use > 0) m_in_use--;
                m_head_valid = 1'b1;
                res.status   = STAT_FREED;
                found        = 1'b0;
                for (int k = 0; k < live_blocks.size() && !found; k++) begin
                    if (live_blocks[k] == req.block_index) begin
                        live_blocks.delete(k);
                        found = 1'b1;
                    end
                end
            end else begin
                res.status = STAT_INVALID;
                n_invalid++;
            end
        end
        res.blocks_in_use = INUSE_W'(m_in_use);
        return res;
    endfunction

    // Mostly a live block, sometimes any index (double or stray free)
    function automatic logic [INDEX_W-1:0] pick_free_index();
        if (live_blocks.size() != 0 && $urandom_range(0, 3) != 0)
            return INDEX_W'(live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
        return INDEX_W'($urandom_range(0, POOL_BLOCKS - 1));
    endfunction

    function automatic t_in_item random_request(input int unsigned alloc_pct);
        t_in_item r;
        r.mode = ($urandom_range(0, 99) < alloc_pct) ? MODE_ALLOC : MODE_FREE;
        if (r.mode == MODE_FREE) r.block_index = pick_free_index();
        else                     r.block_index = INDEX_W'($urandom_range(0, POOL_BLOCKS - 1));
        return r;
    endfunction

    // Offer one request after a random gap; predict its result once transferred
    task automatic send_request(input logic mode, input logic [INDEX_W-1:0] idx);
        int unsigned gap;
        t_in_item    req;
        req.mode        = mode;
        req.block_index = idx;
        gap             = $urandom_range(0, tx_idle_max);
        if (gap > 0) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        pending_results.push_back(pool_step(req));
        n_requests++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DAT_W'(value);
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        pool_config(idx, CFG_DAT_W'(value));
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering and wait until every expected result has come back
    task automatic settle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input longint unsigned exp_val,
                               input longint unsigned act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
            n_errors++;
        end
    endtask

    // Compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: status %0d index %0d in use %0d",
                         $time, out_data.status, out_data.granted_index,
                         out_data.blocks_in_use);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, out_data.status);
                check_field("granted_index", want.granted_index, out_data.granted_index);
                check_field("byte_offset", want.byte_offset, out_data.byte_offset);
                check_field("new_node", want.new_node, out_data.new_node);
                check_field("blocks_in_use", want.blocks_in_use, out_data.blocks_in_use);
            end
        end
    end

    // Result side: random stall after each transfer, plus long hold-offs on request
    always @(negedge i_clk) begin
        if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (results_seen != n_results) begin
            results_seen = n_results;
            rx_wait      = $urandom_range(0, rx_idle_max);
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            out_stall <= 1'b1;
        end else if (rx_wait != 0) begin
            rx_wait--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // End the run when no transfer of any kind happens for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: timeout, %0d results still expected", $time, pending_results.size());
        $display("status: fail");
        $finish;
    end

    // First node sized before any allocation, no growth: exhaust, bad frees, LIFO reuse
    task automatic test_first_node();
        tx_idle_max = 3;
        rx_idle_max = 3;
        write_reg(CFG_BPN, 3);
        write_reg(CFG_ALLOW, 0);
        write_reg(CFG_REQ_BYTES, 1);
        repeat (3) send_request(MODE_ALLOC, '1);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_FREE, 10'd1);
        send_request(MODE_FREE, 10'd1);
        send_request(MODE_FREE, 10'd1023);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_FREE, 10'd0);
        send_request(MODE_FREE, 10'd2);
        send_request(MODE_ALLOC, '1);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_ALLOC, '1);
        settle();
    endtask

    // Growth allowed, a 65536-byte block size, then a zero node size acting as one
    task automatic test_node_growth();
        write_reg(CFG_ALLOW, 1);
        write_reg(CFG_REQ_BYTES, 65536);
        repeat (2) send_request(MODE_ALLOC, '0);
        settle();
        write_reg(CFG_BPN, 0);
        repeat (3) send_request(MODE_ALLOC, '1);
        settle();
    endtask

    // Hold off results long enough that the block fills and stalls its input
    task automatic test_backpressure();
        t_in_item req;
        tx_idle_max = 0;
        rx_idle_max = 0;
        write_reg(CFG_BPN, 4);
        hold_requests++;
        repeat (16) begin
            req = random_request(60);
            send_request(req.mode, req.block_index);
        end
        settle();
    endtask

    // Mixed allocate/free traffic under several settings
    task automatic test_random_churn();
        t_in_item    req;
        int unsigned alloc_pct;
        for (int phase = 0; phase < 4; phase++) begin
            case ($urandom_range(0, 2))
                0:       write_reg(CFG_REQ_BYTES, 1);
                1:       write_reg(CFG_REQ_BYTES, 65536);
                default: write_reg(CFG_REQ_BYTES, $urandom_range(1, 65536));
            endcase
            write_reg(CFG_BPN, $urandom_range(0, 8));
            write_reg(CFG_ALLOW, phase % 2);
            tx_idle_max = (phase == 1) ? 0 : 11;
            rx_idle_max = (phase == 1 || phase == 2) ? 0 : 11;
            alloc_pct   = $urandom_range(55, 70);
            repeat (50) begin
                req = random_request(alloc_pct);
                send_request(req.mode, req.block_index);
            end
            settle();
        end
    endtask

    // Allocate until the whole pool is open and used, then churn at the limit
    task automatic test_fill_pool();
        t_in_item    req;
        int unsigned n_sent;
        tx_idle_max = 11;
        rx_idle_max = 11;
        write_reg(CFG_BPN, 1000);
        write_reg(CFG_ALLOW, 1);
        write_reg(CFG_REQ_BYTES, $urandom_range(1, 65536));
        n_sent = 0;
        while (n_full_exhausted < 4 && n_sent < 1400) begin
            req = random_request(97);
            send_request(req.mode, req.block_index);
            n_sent++;
        end
        repeat (60) begin
            req = random_request(50);
            send_request(req.mode, req.block_index);
        end
        settle();
    endtask

    initial begin
        pool_reset();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_first_node();
        test_node_growth();
        test_backpressure();
        test_random_churn();
        test_fill_pool();
        settle();
        repeat (8) @(posedge i_clk);
        $display("Ran %0d requests, %0d results: %0d nodes opened, %0d exhausted, %0d bad frees",
                 n_requests, n_results, n_new_nodes, n_exhausted, n_invalid);
        $display("Full pool refused %0d allocations; %0d mismatches", n_full_exhausted,
                 n_errors);
        if (n_errors == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
